// ===== rtl/mplf_pkg.sv =====
package mplf_pkg;

  localparam int BYTE_BITS        = 8;
  localparam int LEN_BITS         = 4;
  localparam int NUM_PAT_REGS     = 4;
  localparam int PATTERN_REG_BITS = 64;
  localparam int CFG_ADDR_BITS    = 3;
  localparam int CFG_DATA_BITS    = 64;
  localparam int COUNT_BITS       = 3;
  localparam int TOTAL_BITS       = 8;

  localparam logic [BYTE_BITS-1:0]  NEWLINE_BYTE = 8'd10;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX    = 8'd255;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_MATCH_MODE      = 3'd0,
    REG_PATTERN_COUNT   = 3'd1,
    REG_PATTERN_ZERO    = 3'd2,
    REG_PATTERN_ONE     = 3'd3,
    REG_PATTERN_TWO     = 3'd4,
    REG_PATTERN_THREE   = 3'd5,
    REG_PATTERN_LENGTHS = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic                                            match_mode;
    logic [COUNT_BITS-1:0]                           pattern_count;
    logic [NUM_PAT_REGS-1:0][PATTERN_REG_BITS-1:0]   pattern_bits;
    logic [NUM_PAT_REGS-1:0][LEN_BITS-1:0]           pattern_lengths;
  } cfg_t;

endpackage

// ===== rtl/mplf_cfg_regs.sv =====
module mplf_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [mplf_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [mplf_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  output mplf_pkg::cfg_t                     cfg_r
);
  import mplf_pkg::*;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_MATCH_MODE:      cfg_r.match_mode      <= cfg_wdata[0];
        REG_PATTERN_COUNT:   cfg_r.pattern_count   <= cfg_wdata[COUNT_BITS-1:0];
        REG_PATTERN_ZERO:    cfg_r.pattern_bits[0] <= cfg_wdata[PATTERN_REG_BITS-1:0];
        REG_PATTERN_ONE:     cfg_r.pattern_bits[1] <= cfg_wdata[PATTERN_REG_BITS-1:0];
        REG_PATTERN_TWO:     cfg_r.pattern_bits[2] <= cfg_wdata[PATTERN_REG_BITS-1:0];
        REG_PATTERN_THREE:   cfg_r.pattern_bits[3] <= cfg_wdata[PATTERN_REG_BITS-1:0];
        REG_PATTERN_LENGTHS: cfg_r.pattern_lengths <= cfg_wdata[NUM_PAT_REGS*LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/mplf_matcher.sv =====
module mplf_matcher #(
  parameter int PATTERN_BYTES = 8,
  parameter int PROG_BITS     = 3
) (
  input  logic                                active,
  input  logic [mplf_pkg::LEN_BITS-1:0]       len,
  input  logic [8*PATTERN_BYTES-1:0]          pattern,
  input  logic [PROG_BITS-1:0]                progress,
  input  logic [mplf_pkg::BYTE_BITS-1:0]      text_byte,
  output logic [PROG_BITS-1:0]                progress_nxt,
  output logic                                hit
);
  import mplf_pkg::*;

  logic [PROG_BITS-1:0]                         start;
  logic [PATTERN_BYTES-1:0]                     chr_eq;
  logic [PATTERN_BYTES-1:0][PATTERN_BYTES-1:0]  self_eq;
  logic [PATTERN_BYTES:1]                       cand;
  logic [LEN_BITS-1:0]                          q_best;

  always_comb begin
    for (int a = 0; a < PATTERN_BYTES; a++) begin
      chr_eq[a] = pattern[BYTE_BITS*a +: BYTE_BITS] == text_byte;
      for (int b = 0; b < PATTERN_BYTES; b++) begin
        self_eq[a][b] = pattern[BYTE_BITS*a +: BYTE_BITS] == pattern[BYTE_BITS*b +: BYTE_BITS];
      end
    end
  end

  // progress left over from a longer pattern restarts from nothing
  assign start = (LEN_BITS'(progress) >= len) ? '0 : progress;

  // prefix of length q survives if its last byte is the new one and the rest
  // lines up with the tail of the matched prefix
  always_comb begin
    logic ok;
    ok   = 1'b0;
    cand = '0;
    for (int q = 1; q <= PATTERN_BYTES; q++) begin
      for (int j = q - 1; j < PATTERN_BYTES; j++) begin
        if (PROG_BITS'(j) == start) begin
          ok = chr_eq[q-1];
          for (int t = 0; t < q - 1; t++) begin
            ok = ok & self_eq[t][j+1-q+t];
          end
          cand[q] = ok;
        end
      end
    end
  end

  always_comb begin
    q_best = '0;
    for (int q = 1; q <= PATTERN_BYTES; q++) begin
      if (cand[q]) q_best = LEN_BITS'(q);
    end
  end

  assign hit          = active && (q_best == len);
  assign progress_nxt = (!active || hit) ? '0 : PROG_BITS'(q_best);

endmodule

// ===== rtl/multi_pattern_line_filter.sv =====
// Line filter over a byte stream of log text. One byte is taken per cycle while
// the output does not stall; each byte waits in the input register and its line
// result (if the byte is a newline that gets reported) is then registered in the
// output register. All pattern automata step in parallel, combinationally,
// between the input and output registers. A stalled output holds the input
// register, and input ready then drops after one more byte.
module multi_pattern_line_filter #(
  parameter int NUM_PATTERNS    = 4,
  parameter int PATTERN_BYTES   = 8,
  parameter int LINE_COUNT_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [mplf_pkg::BYTE_BITS-1:0]     in_text_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [LINE_COUNT_BITS-1:0]         out_line_number,
  output logic [mplf_pkg::TOTAL_BITS-1:0]    out_match_total,
  output logic [mplf_pkg::NUM_PAT_REGS-1:0]  out_pattern_found,
  input  logic                               cfg_we,
  input  logic [mplf_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [mplf_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
  import mplf_pkg::*;

  localparam int PROG_BITS = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
  localparam int NUM_BITS  = $clog2(NUM_PATTERNS + 1) > COUNT_BITS ?
                             $clog2(NUM_PATTERNS + 1) : COUNT_BITS;

  cfg_t cfg_r;

  logic                        s1_valid_r;
  logic [BYTE_BITS-1:0]        s1_byte_r;
  logic                        s1_go;

  logic [PROG_BITS-1:0]        prog_r   [NUM_PATTERNS];
  logic [PROG_BITS-1:0]        prog_nxt [NUM_PATTERNS];
  logic [NUM_PATTERNS-1:0]     hit;
  logic [NUM_PATTERNS-1:0]     found_ext;
  logic [NUM_PAT_REGS-1:0]     found_hit;
  logic [NUM_PAT_REGS-1:0]     found_r;
  logic [TOTAL_BITS-1:0]       total_r;
  logic [TOTAL_BITS-1:0]       total_nxt;
  logic [LINE_COUNT_BITS-1:0]  line_r;
  logic [NUM_BITS-1:0]         n_eff;
  logic                        is_newline;
  logic                        all_found;
  logic                        report;

  logic                        out_valid_r;
  logic [LINE_COUNT_BITS-1:0]  out_line_r;
  logic [TOTAL_BITS-1:0]       out_total_r;
  logic [NUM_PAT_REGS-1:0]     out_found_r;

  mplf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg_r     (cfg_r)
  );

  assign n_eff = (NUM_BITS'(cfg_r.pattern_count) > NUM_BITS'(NUM_PATTERNS)) ?
                 NUM_BITS'(NUM_PATTERNS) : NUM_BITS'(cfg_r.pattern_count);

  genvar k;
  generate
    for (k = 0; k < NUM_PATTERNS; k++) begin : g_pat
      if (k < NUM_PAT_REGS) begin : g_live
        logic [LEN_BITS-1:0] len;
        logic                active;
        assign len    = cfg_r.pattern_lengths[k];
        assign active = (NUM_BITS'(k) < n_eff) && (len != '0) &&
                        (len <= LEN_BITS'(PATTERN_BYTES));
        mplf_matcher #(
          .PATTERN_BYTES (PATTERN_BYTES),
          .PROG_BITS     (PROG_BITS)
        ) u_match (
          .active       (active),
          .len          (len),
          .pattern      (cfg_r.pattern_bits[k][8*PATTERN_BYTES-1:0]),
          .progress     (prog_r[k]),
          .text_byte    (s1_byte_r),
          .progress_nxt (prog_nxt[k]),
          .hit          (hit[k])
        );
        assign found_ext[k] = found_r[k];
      end else begin : g_dead
        // no pattern register behind this slot: it never matches
        assign prog_nxt[k]  = '0;
        assign hit[k]       = 1'b0;
        assign found_ext[k] = 1'b0;
      end
    end
    for (k = 0; k < NUM_PAT_REGS; k++) begin : g_found
      if (k < NUM_PATTERNS) begin : g_on
        assign found_hit[k] = hit[k];
      end else begin : g_off
        assign found_hit[k] = 1'b0;
      end
    end
  endgenerate

  // saturating add of this byte's hits
  always_comb begin
    logic [TOTAL_BITS:0] sum;
    sum = {1'b0, total_r};
    for (int i = 0; i < NUM_PATTERNS; i++) begin
      sum = sum + (TOTAL_BITS+1)'(hit[i]);
    end
    total_nxt = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
  end

  always_comb begin
    all_found = 1'b1;
    for (int i = 0; i < NUM_PATTERNS; i++) begin
      if ((NUM_BITS'(i) < n_eff) && !found_ext[i]) all_found = 1'b0;
    end
  end

  assign is_newline = s1_byte_r == NEWLINE_BYTE;
  assign report     = cfg_r.match_mode ? all_found : (total_r != '0);
  assign s1_go      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_byte_r <= in_text_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PATTERNS; i++) prog_r[i] <= '0;
      found_r <= '0;
      total_r <= '0;
      line_r  <= LINE_COUNT_BITS'(1);
    end else if (s1_go) begin
      if (is_newline) begin
        // drop the line state, advance the line number up to its ceiling
        for (int i = 0; i < NUM_PATTERNS; i++) prog_r[i] <= '0;
        found_r <= '0;
        total_r <= '0;
        if (line_r != '1) line_r <= line_r + LINE_COUNT_BITS'(1);
      end else begin
        for (int i = 0; i < NUM_PATTERNS; i++) prog_r[i] <= prog_nxt[i];
        found_r <= found_r | found_hit;
        total_r <= total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && is_newline && report) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && is_newline && report) begin
      out_line_r  <= line_r;
      out_total_r <= total_r;
      out_found_r <= found_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_line_number   = out_line_r;
  assign out_match_total   = out_total_r;
  assign out_pattern_found = out_found_r;

endmodule

// ===== rtl/mplf_checker.sv =====
module mplf_checker #(
  parameter int LINE_COUNT_BITS = 32
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic [mplf_pkg::BYTE_BITS-1:0]     in_text_byte,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [LINE_COUNT_BITS-1:0]         out_line_number,
  input logic [mplf_pkg::TOTAL_BITS-1:0]    out_match_total,
  input logic [mplf_pkg::NUM_PAT_REGS-1:0]  out_pattern_found
);
  import mplf_pkg::*;

  // a waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_line_number) &&
    $stable(out_match_total) && $stable(out_pattern_found))
    else $error("result changed while stalled");

  // a fresh result follows an accepted newline byte
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_text_byte == NEWLINE_BYTE, 2))
    else $error("result without a newline");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_line_number != '0)
    else $error("line number zero");

  a_total_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_match_total != '0) == (out_pattern_found != '0))
    else $error("total and found mask disagree");

endmodule

bind multi_pattern_line_filter mplf_checker #(
  .LINE_COUNT_BITS (LINE_COUNT_BITS)
) u_mplf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .in_text_byte      (in_text_byte),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_line_number   (out_line_number),
  .out_match_total   (out_match_total),
  .out_pattern_found (out_pattern_found)
);
